// ===== rtl/upi_pkg.sv =====
`default_nettype none
package upi_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 24;

    localparam logic [1:0] MODE_EULER = 2'd0;
    localparam logic [1:0] MODE_MID   = 2'd1;
    localparam logic [1:0] MODE_ARC   = 2'd2;

    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_STEP_TIME  = 3'd1,
        REG_START_X    = 3'd2,
        REG_START_Y    = 3'd3,
        REG_START_HEAD = 3'd4
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE,
        ST_ANG_LO,
        ST_ANG_HI,
        ST_ANG_SUM,
        ST_SETUP,
        ST_DIV,
        ST_DIV_END,
        ST_COR_INIT,
        ST_COR_RUN,
        ST_COR_END,
        ST_PROD_LO,
        ST_PROD_HI,
        ST_PROD_SUM,
        ST_APPLY,
        ST_DONE
    } state_t;

    localparam logic [24:0] STEP_TIME_RESET = 25'd167772;
    // 1 / (2 pi) in units of 2^-32.
    localparam logic [31:0] TWO_PI_INV_Q32 = 32'd683565276;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam logic [31:0] ATAN_BAM [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage
`default_nettype wire

// ===== rtl/unicycle_pose_integrator.sv =====
// One item at a time; a new item is accepted only in idle, once the previous result has
// been offered. Arc items with a nonzero yaw rate pass through the 48-step divider and
// two CORDIC rotations, all other items through one rotation; every product comes from
// one 32x32 multiplier.
// Reset (rst_n low, asynchronous) clears the pose to zero, mode to Euler and
// restores the default step time; no item is pending afterwards.
`default_nettype none
module unicycle_pose_integrator #(
    parameter int CORDIC_ITERATIONS = upi_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // speed [31:0], yaw_rate [63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // pos_x [31:0], pos_y [63:32], heading_out [95:64]
    output logic [0:0]       m_tuser,   // saturated [0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    upi_pkg::state_t state_reg, state_next;

    logic [1:0]  mode_reg;
    logic [24:0] step_time_reg;
    logic [31:0] pose_x_reg, pose_y_reg, pose_h_reg;

    logic [31:0] v_mag_reg, w_mag_reg;
    logic        v_neg_reg, w_neg_reg;
    logic        arc_reg, sat_reg, axis_reg, pass_reg;

    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [31:0] mul_a, mul_b;
    logic [87:0] acc_reg;
    logic [56:0] magp_reg, magd_reg;
    logic [31:0] h1_reg, hm_reg;

    logic [47:0] dq_reg;
    logic [31:0] rem_reg;
    logic [5:0]  div_cnt_reg;
    logic [31:0] r_mag_reg;
    logic        r_neg_reg;

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic        flip_reg;
    logic [4:0]  cor_cnt_reg;
    logic signed [31:0] c0_reg, s0_reg, c1_reg, s1_reg;

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic        m_tuser_reg;

    // Angle rounding from the accumulated rate product.
    logic [87:0] sum40, sum41;
    logic [31:0] ang40, ang41, h1_calc, hm_calc;
    assign sum40   = acc_reg + (88'd1 << 39);
    assign sum41   = acc_reg + (88'd1 << 40);
    assign ang40   = sum40[71:40];
    assign ang41   = sum41[72:41];
    assign h1_calc = pose_h_reg + (w_neg_reg ? (32'd0 - ang40) : ang40);
    assign hm_calc = (mode_reg == upi_pkg::MODE_MID)
                   ? pose_h_reg + (w_neg_reg ? (32'd0 - ang41) : ang41) : pose_h_reg;

    // Divider step.
    logic [32:0] rem_sh, rem_sub;
    logic        q_bit;
    assign rem_sh  = {rem_reg, dq_reg[47]};
    assign rem_sub = rem_sh - {1'b0, w_mag_reg};
    assign q_bit   = (rem_sh >= {1'b0, w_mag_reg});

    // CORDIC setup and step.
    logic [31:0] cor_ang, ang_off, ang_rot;
    logic        flip_calc;
    assign cor_ang   = arc_reg ? (pass_reg ? h1_reg : pose_h_reg) : hm_reg;
    assign ang_off   = cor_ang - 32'h40000000;
    assign flip_calc = ~ang_off[31];
    assign ang_rot   = flip_calc ? cor_ang - 32'h80000000 : cor_ang;

    logic signed [33:0] x_sh, y_sh, atan_s, x_cl, y_cl, x_fin, y_fin;
    assign x_sh   = x_reg >>> cor_cnt_reg;
    assign y_sh   = y_reg >>> cor_cnt_reg;
    assign atan_s = $signed({2'b00, upi_pkg::ATAN_BAM[cor_cnt_reg]});
    assign x_cl   = (x_reg > upi_pkg::ONE_Q30) ? upi_pkg::ONE_Q30
                  : (x_reg < -upi_pkg::ONE_Q30) ? -upi_pkg::ONE_Q30 : x_reg;
    assign y_cl   = (y_reg > upi_pkg::ONE_Q30) ? upi_pkg::ONE_Q30
                  : (y_reg < -upi_pkg::ONE_Q30) ? -upi_pkg::ONE_Q30 : y_reg;
    assign x_fin  = flip_reg ? -x_cl : x_cl;
    assign y_fin  = flip_reg ? -y_cl : y_cl;

    // Operands of the per-axis product.
    logic signed [31:0] comp;
    logic [31:0]        comp_mag;
    logic signed [32:0] diff;
    logic [31:0]        diff_mag;
    assign comp     = axis_reg ? s0_reg : c0_reg;
    assign comp_mag = comp[31] ? 32'd0 - 32'(comp) : 32'(comp);
    assign diff     = axis_reg ? (33'(c0_reg) - 33'(c1_reg)) : (33'(s1_reg) - 33'(s0_reg));
    assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];

    // Displacement rounding and saturating pose update.
    logic [87:0]        sum_rnd;
    logic [33:0]        d_mag;
    logic               d_neg;
    logic signed [35:0] d_s, pos_sum;
    logic [31:0]        pos_cur, pos_new;
    logic               pos_sat;
    assign sum_rnd = arc_reg ? acc_reg + (88'd1 << 29) : acc_reg + (88'd1 << 53);
    assign d_mag   = arc_reg ? sum_rnd[63:30] : sum_rnd[87:54];
    assign d_neg   = arc_reg ? (r_neg_reg ^ diff[32]) : (v_neg_reg ^ comp[31]);
    assign d_s     = d_neg ? -$signed({2'b00, d_mag}) : $signed({2'b00, d_mag});
    assign pos_cur = axis_reg ? pose_y_reg : pose_x_reg;
    assign pos_sum = 36'($signed(pos_cur)) + d_s;
    always_comb
    begin
        pos_sat = 1'b1;
        if (pos_sum > 36'sd2147483647)
        begin
            pos_new = 32'h7FFFFFFF;
        end
        else if (pos_sum < -36'sd2147483648)
        begin
            pos_new = 32'h80000000;
        end
        else
        begin
            pos_new = pos_sum[31:0];
            pos_sat = 1'b0;
        end
    end

    logic out_free;
    assign out_free = ~m_tvalid_reg | m_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            upi_pkg::ST_IDLE:     if (s_tvalid && !cfg_valid) state_next = upi_pkg::ST_RATE;
            upi_pkg::ST_RATE:     state_next = upi_pkg::ST_ANG_LO;
            upi_pkg::ST_ANG_LO:   state_next = upi_pkg::ST_ANG_HI;
            upi_pkg::ST_ANG_HI:   state_next = upi_pkg::ST_ANG_SUM;
            upi_pkg::ST_ANG_SUM:  state_next = upi_pkg::ST_SETUP;
            upi_pkg::ST_SETUP:
            begin
                if (mode_reg == upi_pkg::MODE_ARC && w_mag_reg != 32'd0)
                    state_next = upi_pkg::ST_DIV;
                else
                    state_next = upi_pkg::ST_COR_INIT;
            end
            upi_pkg::ST_DIV:      if (div_cnt_reg == 6'd47) state_next = upi_pkg::ST_DIV_END;
            upi_pkg::ST_DIV_END:  state_next = upi_pkg::ST_COR_INIT;
            upi_pkg::ST_COR_INIT: state_next = upi_pkg::ST_COR_RUN;
            upi_pkg::ST_COR_RUN:
            begin
                if (cor_cnt_reg == 5'(CORDIC_ITERATIONS - 1))
                    state_next = upi_pkg::ST_COR_END;
            end
            upi_pkg::ST_COR_END:
            begin
                if (arc_reg && !pass_reg)
                    state_next = upi_pkg::ST_COR_INIT;
                else
                    state_next = upi_pkg::ST_PROD_LO;
            end
            upi_pkg::ST_PROD_LO:  state_next = upi_pkg::ST_PROD_HI;
            upi_pkg::ST_PROD_HI:
            begin
                if (arc_reg)
                    state_next = upi_pkg::ST_APPLY;
                else
                    state_next = upi_pkg::ST_PROD_SUM;
            end
            upi_pkg::ST_PROD_SUM: state_next = upi_pkg::ST_APPLY;
            upi_pkg::ST_APPLY:
            begin
                if (axis_reg)
                    state_next = upi_pkg::ST_DONE;
                else
                    state_next = upi_pkg::ST_PROD_LO;
            end
            upi_pkg::ST_DONE:     if (out_free) state_next = upi_pkg::ST_IDLE;
            default:              state_next = upi_pkg::ST_IDLE;
        endcase
    end

    // Handshake and multiplier operand selection.
    // A configuration write takes precedence over an item in the same cycle.
    always_comb
    begin
        s_tready = (state_reg == upi_pkg::ST_IDLE) && !cfg_valid;
        mul_a    = 32'd0;
        mul_b    = 32'd0;
        case (state_reg)
            upi_pkg::ST_RATE:
            begin
                mul_a = w_mag_reg;
                mul_b = {7'd0, step_time_reg};
            end
            upi_pkg::ST_ANG_LO:
            begin
                mul_a = prod_reg[31:0];
                mul_b = upi_pkg::TWO_PI_INV_Q32;
            end
            upi_pkg::ST_ANG_HI:
            begin
                mul_a = {7'd0, magp_reg[56:32]};
                mul_b = upi_pkg::TWO_PI_INV_Q32;
            end
            upi_pkg::ST_ANG_SUM:
            begin
                mul_a = v_mag_reg;
                mul_b = {7'd0, step_time_reg};
            end
            upi_pkg::ST_PROD_LO:
            begin
                mul_a = arc_reg ? r_mag_reg : magd_reg[31:0];
                mul_b = arc_reg ? diff_mag : comp_mag;
            end
            upi_pkg::ST_PROD_HI:
            begin
                mul_a = {7'd0, magd_reg[56:32]};
                mul_b = comp_mag;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= upi_pkg::ST_IDLE;
            mode_reg      <= upi_pkg::MODE_EULER;
            step_time_reg <= upi_pkg::STEP_TIME_RESET;
            pose_x_reg    <= 32'd0;
            pose_y_reg    <= 32'd0;
            pose_h_reg    <= 32'd0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == upi_pkg::ST_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (state_reg == upi_pkg::ST_APPLY)
            begin
                if (axis_reg)
                begin
                    pose_y_reg <= pos_new;
                    pose_h_reg <= h1_reg;
                end
                else
                begin
                    pose_x_reg <= pos_new;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (upi_pkg::reg_index_t'(cfg_index))
                    upi_pkg::REG_MODE:       mode_reg      <= cfg_data[1:0];
                    upi_pkg::REG_STEP_TIME:  step_time_reg <= cfg_data[24:0];
                    upi_pkg::REG_START_X:    pose_x_reg    <= cfg_data;
                    upi_pkg::REG_START_Y:    pose_y_reg    <= cfg_data;
                    upi_pkg::REG_START_HEAD: pose_h_reg    <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (state_reg)
            upi_pkg::ST_IDLE:
            begin
                v_neg_reg <= s_tdata[31];
                w_neg_reg <= s_tdata[63];
                v_mag_reg <= s_tdata[31] ? 32'd0 - s_tdata[31:0] : s_tdata[31:0];
                w_mag_reg <= s_tdata[63] ? 32'd0 - s_tdata[63:32] : s_tdata[63:32];
                sat_reg   <= 1'b0;
            end
            upi_pkg::ST_ANG_LO:  magp_reg <= prod_reg[56:0];
            upi_pkg::ST_ANG_HI:  acc_reg  <= {24'd0, prod_reg};
            upi_pkg::ST_ANG_SUM: acc_reg  <= acc_reg + {prod_reg[55:0], 32'd0};
            upi_pkg::ST_SETUP:
            begin
                magd_reg    <= prod_reg[56:0];
                h1_reg      <= h1_calc;
                hm_reg      <= hm_calc;
                arc_reg     <= (mode_reg == upi_pkg::MODE_ARC) && (w_mag_reg != 32'd0);
                pass_reg    <= 1'b0;
                axis_reg    <= 1'b0;
                dq_reg      <= {v_mag_reg, 16'd0};
                rem_reg     <= 32'd0;
                div_cnt_reg <= 6'd0;
            end
            upi_pkg::ST_DIV:
            begin
                rem_reg     <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
                dq_reg      <= {dq_reg[46:0], q_bit};
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end
            upi_pkg::ST_DIV_END:
            begin
                r_neg_reg <= v_neg_reg ^ w_neg_reg;
                if (!(v_neg_reg ^ w_neg_reg) && dq_reg > 48'h7FFFFFFF)
                begin
                    r_mag_reg <= 32'h7FFFFFFF;
                    sat_reg   <= 1'b1;
                end
                else if ((v_neg_reg ^ w_neg_reg) && dq_reg > 48'h80000000)
                begin
                    r_mag_reg <= 32'h80000000;
                    sat_reg   <= 1'b1;
                end
                else
                begin
                    r_mag_reg <= dq_reg[31:0];
                end
            end
            upi_pkg::ST_COR_INIT:
            begin
                x_reg       <= upi_pkg::CORDIC_GAIN_Q30;
                y_reg       <= 34'sd0;
                z_reg       <= 34'($signed(ang_rot));
                flip_reg    <= flip_calc;
                cor_cnt_reg <= 5'd0;
            end
            upi_pkg::ST_COR_RUN:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_s;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_s;
                end
                cor_cnt_reg <= cor_cnt_reg + 5'd1;
            end
            upi_pkg::ST_COR_END:
            begin
                if (arc_reg && pass_reg)
                begin
                    c1_reg <= x_fin[31:0];
                    s1_reg <= y_fin[31:0];
                end
                else
                begin
                    c0_reg <= x_fin[31:0];
                    s0_reg <= y_fin[31:0];
                end
                pass_reg <= 1'b1;
            end
            upi_pkg::ST_PROD_HI:  acc_reg <= {24'd0, prod_reg};
            upi_pkg::ST_PROD_SUM: acc_reg <= acc_reg + {prod_reg[55:0], 32'd0};
            upi_pkg::ST_APPLY:
            begin
                axis_reg <= 1'b1;
                if (pos_sat)
                    sat_reg <= 1'b1;
            end
            upi_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {pose_h_reg, pose_y_reg, pose_x_reg};
                    m_tuser_reg <= sat_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign cfg_ready = (state_reg == upi_pkg::ST_IDLE);

endmodule
`default_nettype wire

// ===== bench/tb_unicycle_pose_integrator.sv =====
`default_nettype none
module tb_unicycle_pose_integrator;

    localparam int ITER = upi_pkg::CORDIC_ITERATIONS_DEF;
    localparam int SETTLE_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] heading;
        logic        sat;
    } pose_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // Shadow of the block's registers and pose.
    logic [1:0]  mdl_mode;
    logic [24:0] mdl_step;
    logic [31:0] mdl_x;
    logic [31:0] mdl_y;
    logic [31:0] mdl_heading;

    pose_t expected_poses[$];
    int    errors;
    int    items_sent;
    int    results_seen;
    int    sat_seen;
    int    idle_count;
    int    hold_left;
    int    stall_left;
    bit    no_idle;

    unicycle_pose_integrator u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bit [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // round(a * b / 2^s), half up, split so no partial product overflows.
    function automatic bit [63:0] mul_round(bit [63:0] a, bit [63:0] b, int s);
        bit [63:0] hi;
        bit [63:0] lo;
        bit [63:0] t;
        hi = a >> 28;
        lo = a & 64'h0FFF_FFFF;
        t = lo * b + (64'd1 << (s - 1));
        return (hi * b + (t >> 28)) >> (s - 28);
    endfunction

    function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                    output longint s);
        bit        flip;
        longint    x;
        longint    y;
        longint    z;
        longint    nx;
        longint    step_ang;
        logic [31:0] a;
        logic [31:0] t;
        flip = 0;
        a = ang;
        t = a - 32'h4000_0000;
        // Fold the left half-plane onto the right one and negate afterwards.
        if (t < 32'h8000_0000)
        begin
            a = a - 32'h8000_0000;
            flip = 1;
        end
        x = upi_pkg::CORDIC_GAIN_Q30;
        y = 0;
        z = $signed(a);
        for (int i = 0; i < ITER; i++)
        begin
            step_ang = upi_pkg::ATAN_BAM[i];
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - step_ang;
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + step_ang;
            end
            x = nx;
        end
        if (x > upi_pkg::ONE_Q30) x = upi_pkg::ONE_Q30;
        if (x < -upi_pkg::ONE_Q30) x = -upi_pkg::ONE_Q30;
        if (y > upi_pkg::ONE_Q30) y = upi_pkg::ONE_Q30;
        if (y < -upi_pkg::ONE_Q30) y = -upi_pkg::ONE_Q30;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [31:0] turn_angle(longint rate, int s);
        longint      p;
        longint      st;
        logic [31:0] m;
        st = mdl_step;
        p = rate * st;
        m = 32'(mul_round(magnitude(p), 64'(upi_pkg::TWO_PI_INV_Q32), s));
        return p < 0 ? -m : m;
    endfunction

    function automatic longint scale_by(longint d, longint f);
        longint m;
        m = mul_round(magnitude(d), magnitude(f), 54);
        return ((d < 0) != (f < 0)) ? -m : m;
    endfunction

    function automatic longint round_q30(longint p);
        longint m;
        m = (magnitude(p) + (64'd1 << 29)) >> 30;
        return p < 0 ? -m : m;
    endfunction

    function automatic logic [31:0] clamp_add(logic [31:0] pos, longint d, inout logic sat);
        longint r;
        r = longint'($signed(pos)) + d;
        if (r > 64'sd2147483647)
        begin
            sat = 1;
            r = 64'sd2147483647;
        end
        if (r < -64'sd2147483648)
        begin
            sat = 1;
            r = -64'sd2147483648;
        end
        return r[31:0];
    endfunction

    function automatic pose_t advance_pose(logic [31:0] speed, logic [31:0] yaw);
        longint      v;
        longint      w;
        longint      dx;
        longint      dy;
        longint      c0;
        longint      s0;
        longint      c1;
        longint      s1;
        longint      r;
        longint      d;
        longint      st;
        logic [31:0] h0;
        logic [31:0] h1;
        logic [31:0] hm;
        logic        sat;
        pose_t       p;
        v = $signed(speed);
        w = $signed(yaw);
        st = mdl_step;
        sat = 0;
        h0 = mdl_heading;
        h1 = h0 + turn_angle(w, 40);
        if (mdl_mode == upi_pkg::MODE_ARC && w != 0)
        begin
            r = (v * 65536) / w;
            if (r > 64'sd2147483647)
            begin
                r = 64'sd2147483647;
                sat = 1;
            end
            if (r < -64'sd2147483648)
            begin
                r = -64'sd2147483648;
                sat = 1;
            end
            sin_cos(h0, c0, s0);
            sin_cos(h1, c1, s1);
            dx = round_q30(r * (s1 - s0));
            dy = round_q30(r * (c0 - c1));
        end
        else
        begin
            d = v * st;
            hm = (mdl_mode == upi_pkg::MODE_MID) ? h0 + turn_angle(w, 41) : h0;
            sin_cos(hm, c0, s0);
            dx = scale_by(d, c0);
            dy = scale_by(d, s0);
        end
        mdl_x = clamp_add(mdl_x, dx, sat);
        mdl_y = clamp_add(mdl_y, dy, sat);
        mdl_heading = h1;
        p.x = mdl_x;
        p.y = mdl_y;
        p.heading = h1;
        p.sat = sat;
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_rate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom;
        if (r < 55) return $signed($urandom_range(0, 262144)) - 131072;
        if (r < 80) return $signed($urandom_range(0, 4194304)) - 2097152;
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on result %0d: %s got %h expected %h", results_seen, field,
                 got, want);
    endtask

    // Called and returns at a falling edge; tvalid stays high after acceptance.
    task automatic send_sample(logic [31:0] speed, logic [31:0] yaw);
        int gap;
        pose_t p;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1;
        s_tdata = {yaw, speed};
        do @(posedge clk); while (!s_tready);
        p = advance_pose(speed, yaw);
        expected_poses.push_back(p);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 0;
        while (expected_poses.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(upi_pkg::reg_index_t idx, logic [31:0] data);
        drain();
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            upi_pkg::REG_MODE:       mdl_mode = data[1:0];
            upi_pkg::REG_STEP_TIME:  mdl_step = data[24:0];
            upi_pkg::REG_START_X:    mdl_x = data;
            upi_pkg::REG_START_Y:    mdl_y = data;
            upi_pkg::REG_START_HEAD: mdl_heading = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic test_directed();
        // Field extremes at the reset defaults first, then every mode, the unused one too.
        send_sample(32'h0, 32'h0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        for (int m = 0; m < 4; m++)
        begin
            write_reg(upi_pkg::REG_MODE, m);
            send_sample(32'h0001_0000, 32'h0001_0000);
            send_sample(32'hFFFF_0000, 32'hFFFF_FFFF);
            send_sample(32'h0010_0000, 32'h0);
        end
        // Arc with a tiny yaw rate saturates the turn radius.
        write_reg(upi_pkg::REG_MODE, 32'(upi_pkg::MODE_ARC));
        send_sample(32'h7FFF_FFFF, 32'h1);
        // Position overflow at both ends, then the longest and the zero step time.
        write_reg(upi_pkg::REG_MODE, 32'(upi_pkg::MODE_EULER));
        write_reg(upi_pkg::REG_STEP_TIME, 32'h0100_0000);
        write_reg(upi_pkg::REG_START_X, 32'h7FFF_0000);
        write_reg(upi_pkg::REG_START_Y, 32'h8000_1000);
        write_reg(upi_pkg::REG_START_HEAD, 32'hE000_0000);
        send_sample(32'h7FFF_FFFF, 32'h0);
        send_sample(32'h8000_0000, 32'h0);
        write_reg(upi_pkg::REG_STEP_TIME, 32'h01FF_FFFF);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        write_reg(upi_pkg::REG_STEP_TIME, 32'h0);
        send_sample(32'h1234_5678, 32'h7FFF_FFFF);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(upi_pkg::REG_MODE, $urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0: write_reg(upi_pkg::REG_STEP_TIME, 32'h0100_0000);
                1: write_reg(upi_pkg::REG_STEP_TIME, 32'(upi_pkg::STEP_TIME_RESET));
                2: write_reg(upi_pkg::REG_STEP_TIME, $urandom_range(0, 3));
                default: write_reg(upi_pkg::REG_STEP_TIME, $urandom_range(0, 32'h01FF_FFFF));
            endcase
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(upi_pkg::REG_START_X, $urandom);
                write_reg(upi_pkg::REG_START_Y, $urandom);
                write_reg(upi_pkg::REG_START_HEAD, $urandom);
            end
            no_idle = (ph == 5);
            for (int i = 0; i < 110; i++)
                send_sample(pick_rate(), pick_rate());
            no_idle = 0;
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 6; i++)
            send_sample(pick_rate(), pick_rate());
        drain();
        for (int i = 0; i < 60; i++)
            send_sample(pick_rate(), pick_rate());
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready = 0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            m_tready = 0;
            stall_left--;
        end
        else
        begin
            m_tready = 1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        pose_t p;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_poses.size() == 0)
            begin
                errors++;
                $display("result with no item waiting: %h", m_tdata);
            end
            else
            begin
                p = expected_poses.pop_front();
                if (m_tdata[31:0] !== p.x) report_mismatch("pos_x", m_tdata[31:0], p.x);
                if (m_tdata[63:32] !== p.y) report_mismatch("pos_y", m_tdata[63:32], p.y);
                if (m_tdata[95:64] !== p.heading)
                    report_mismatch("heading_out", m_tdata[95:64], p.heading);
                if (m_tuser[0] !== p.sat)
                    report_mismatch("saturated", 32'(m_tuser), 32'(p.sat));
                if (p.sat) sat_seen++;
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        sat_seen = 0;
        idle_count = 0;
        hold_left = 0;
        stall_left = 0;
        no_idle = 0;
        mdl_mode = upi_pkg::MODE_EULER;
        mdl_step = upi_pkg::STEP_TIME_RESET;
        mdl_x = '0;
        mdl_y = '0;
        mdl_heading = '0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        drain();
        $display("Covered %0d items in Euler, midpoint, arc and unused modes; %0d results",
                 items_sent, results_seen);
        $display("with %0d saturated steps, across step times from zero to the field maximum.",
                 sat_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
